FILE: sv/assert_macros.svh
// Assertion macros shared by the occupancy grid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define OG_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("occupancy grid assertion failed");

// Next-cycle implication, checked on the rising edge of clk_i outside reset.
`define OG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("occupancy grid assertion failed");

`endif

FILE: sv/ogrid_pkg.sv
// Types, codes and defaults shared by the occupancy grid modules.
`timescale 1ns / 1ps

package ogrid_pkg;

  localparam int unsigned ROWS_PER_SIDE_DEF = 256;
  localparam int unsigned ROW_BITS_DEF      = 64;
  localparam int unsigned COORD_W           = 32;
  localparam int unsigned COUNT_W           = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MARKED = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      occupied;
    logic [COUNT_W-1:0]        marked_count;
    logic signed [COORD_W-1:0] low_x;
    logic signed [COORD_W-1:0] high_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] high_y;
  } out_item_t;

  // Outcome of evaluating one row word.
  typedef struct packed {
    logic [1:0] status;
    logic       occupied;
    logic       write;
    logic       update;
    logic       bump;
  } row_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [COORD_W-1:0] low_x;
    logic signed [COORD_W-1:0] high_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] high_y;
  } stats_t;

endpackage

FILE: sv/ogrid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ogrid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2 * ogrid_pkg::ROWS_PER_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ogrid_rowop.sv
// Evaluates one row word for an add or a query and builds the updated word.
`timescale 1ns / 1ps

module ogrid_rowop #(
  parameter int unsigned ROW_BITS = ogrid_pkg::ROW_BITS_DEF
) (
  input  logic [1:0]                                      opcode_i,
  input  logic [ogrid_pkg::COORD_W-1:0]                   cell_x_i,
  input  logic                                            row_ok_i,
  input  logic                                            started_i,
  input  logic [ogrid_pkg::COORD_W+2*ROW_BITS:0]          rdata_i,
  output logic [ogrid_pkg::COORD_W+2*ROW_BITS:0]          wdata_o,
  output ogrid_pkg::row_res_t                             res_o
);

  localparam int unsigned CW     = ogrid_pkg::COORD_W;
  localparam int unsigned WORD_W = 1 + CW + 2 * ROW_BITS;
  localparam int unsigned BIT_W  = $clog2(ROW_BITS);

  logic                anchor;
  logic [CW-1:0]       col_origin;
  logic [ROW_BITS-1:0] left_bits;
  logic [ROW_BITS-1:0] right_bits;
  logic [CW:0]         dx;
  logic [CW:0]         cx;
  logic                on_left;
  logic                col_ok;
  logic [BIT_W-1:0]    bit_idx;
  logic [ROW_BITS-1:0] mask;
  logic                hit;

  assign anchor     = rdata_i[WORD_W-1];
  assign col_origin = rdata_i[WORD_W-2 -: CW];
  assign left_bits  = rdata_i[2*ROW_BITS-1:ROW_BITS];
  assign right_bits = rdata_i[ROW_BITS-1:0];

  // Offset from the row's column anchor; negative offsets map to the left bitmap.
  assign dx      = {cell_x_i[CW-1], cell_x_i} - {col_origin[CW-1], col_origin};
  assign cx      = ~dx;
  assign on_left = dx[CW];
  assign col_ok  = on_left ? (cx < (CW+1)'(ROW_BITS)) : (dx < (CW+1)'(ROW_BITS));
  assign bit_idx = on_left ? cx[BIT_W-1:0] : dx[BIT_W-1:0];
  assign mask    = ROW_BITS'(1) << bit_idx;
  assign hit     = on_left ? left_bits[bit_idx] : right_bits[bit_idx];

  always_comb begin
    res_o   = '0;
    wdata_o = rdata_i;
    res_o.status = ogrid_pkg::ST_DONE;
    if (opcode_i == ogrid_pkg::OP_ADD) begin
      if (!row_ok_i) begin
        res_o.status = ogrid_pkg::ST_RANGE;
      end else if (!anchor) begin
        // First cell of this row sets its column anchor at bit zero on the right.
        wdata_o        = {1'b1, cell_x_i, {ROW_BITS{1'b0}}, ROW_BITS'(1)};
        res_o.write    = 1'b1;
        res_o.update   = 1'b1;
        res_o.bump     = 1'b1;
        res_o.occupied = 1'b1;
      end else if (!col_ok) begin
        res_o.status = ogrid_pkg::ST_RANGE;
      end else if (hit) begin
        res_o.status   = ogrid_pkg::ST_MARKED;
        res_o.update   = 1'b1;
        res_o.occupied = 1'b1;
      end else begin
        if (on_left) begin
          wdata_o = {1'b1, col_origin, left_bits | mask, right_bits};
        end else begin
          wdata_o = {1'b1, col_origin, left_bits, right_bits | mask};
        end
        res_o.write    = 1'b1;
        res_o.update   = 1'b1;
        res_o.bump     = 1'b1;
        res_o.occupied = 1'b1;
      end
    end else if (opcode_i == ogrid_pkg::OP_QUERY) begin
      if (started_i) begin
        if (!row_ok_i) begin
          res_o.status = ogrid_pkg::ST_RANGE;
        end else if (anchor) begin
          if (!col_ok) begin
            res_o.status = ogrid_pkg::ST_RANGE;
          end else begin
            res_o.occupied = hit;
          end
        end
      end
    end
  end

endmodule

FILE: sv/ogrid_stats.sv
// Tracks the start flag, the marked-cell count and the extent of added cells.
`timescale 1ns / 1ps

module ogrid_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          update_i,
  input  logic                          bump_i,
  input  logic [ogrid_pkg::COORD_W-1:0] cell_x_i,
  input  logic [ogrid_pkg::COORD_W-1:0] cell_y_i,
  output logic                          started_o,
  output ogrid_pkg::stats_t             stats_next_o
);

  logic              started_q, started_d;
  ogrid_pkg::stats_t stats_q, stats_d;

  always_comb begin
    started_d = started_q;
    stats_d   = stats_q;
    if (clear_i) begin
      started_d = 1'b0;
      stats_d   = '0;
    end else begin
      if (update_i) begin
        if (!started_q) begin
          started_d      = 1'b1;
          stats_d.low_x  = cell_x_i;
          stats_d.high_x = cell_x_i;
          stats_d.low_y  = cell_y_i;
          stats_d.high_y = cell_y_i;
        end else begin
          if ($signed(cell_x_i) < $signed(stats_q.low_x))  stats_d.low_x  = cell_x_i;
          if ($signed(cell_x_i) > $signed(stats_q.high_x)) stats_d.high_x = cell_x_i;
          if ($signed(cell_y_i) < $signed(stats_q.low_y))  stats_d.low_y  = cell_y_i;
          if ($signed(cell_y_i) > $signed(stats_q.high_y)) stats_d.high_y = cell_y_i;
        end
      end
      if (bump_i && (stats_q.count != ogrid_pkg::COUNT_MAX)) begin
        stats_d.count = stats_q.count + ogrid_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      stats_q   <= '0;
    end else begin
      started_q <= started_d;
      stats_q   <= stats_d;
    end
  end

  assign started_o    = started_q;
  assign stats_next_o = stats_d;

endmodule

FILE: sv/anchored_occupancy_grid.sv
// An accepted transaction moves to S_EXEC, which registers its result in the output register.
// Transactions do not overlap; each one does a single read-modify-write of the row memory.
// Clear returns its result and then runs a pass over every slot that zeroes the row memory.
// Reset is asynchronous, active low, and starts the same clearing pass;
// no input is accepted until that pass ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module anchored_occupancy_grid #(
  parameter int unsigned ROWS_PER_SIDE = ogrid_pkg::ROWS_PER_SIDE_DEF,
  parameter int unsigned ROW_BITS      = ogrid_pkg::ROW_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ogrid_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ogrid_pkg::out_item_t out_item_o
);

  localparam int unsigned CW     = ogrid_pkg::COORD_W;
  localparam int unsigned SLOTS  = 2 * ROWS_PER_SIDE;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned WORD_W = 1 + CW + 2 * ROW_BITS;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [SLOT_W-1:0]   clr_cnt_q, clr_cnt_d;
  ogrid_pkg::in_item_t item_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                row_ok_q;
  logic [CW-1:0]       row_origin_q, row_origin_d;
  logic                out_valid_q, out_valid_d;
  ogrid_pkg::out_item_t out_item_q, out_item_d;

  logic                accept;
  logic [CW-1:0]       row_base;
  logic [CW:0]         dy;
  logic [CW:0]         ry;
  logic                row_ok;
  logic [SLOT_W-1:0]   slot;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   row_wdata;

  logic                started;
  logic                exec_add;
  logic                exec_clear;
  ogrid_pkg::row_res_t row_res;
  ogrid_pkg::stats_t   stats_next;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Row slot: offsets at or above the row anchor count up from zero, those below
  // fill the upper half. Before the first add, an add anchors on its own row.
  assign row_base = started ? row_origin_q : in_item_i.cell_y;
  assign dy       = {in_item_i.cell_y[CW-1], in_item_i.cell_y} - {row_base[CW-1], row_base};
  assign ry       = ~dy;
  assign row_ok   = dy[CW] ? (ry < (CW+1)'(ROWS_PER_SIDE)) : (dy < (CW+1)'(ROWS_PER_SIDE));
  assign slot     = dy[CW] ? (SLOT_W'(ROWS_PER_SIDE) + ry[SLOT_W-1:0]) : dy[SLOT_W-1:0];

  assign exec_add   = (state_q == S_EXEC) && (item_q.opcode == ogrid_pkg::OP_ADD);
  assign exec_clear = (state_q == S_EXEC) && (item_q.opcode == ogrid_pkg::OP_CLEAR);

  ogrid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  ogrid_rowop #(
    .ROW_BITS (ROW_BITS)
  ) u_rowop (
    .opcode_i  (item_q.opcode),
    .cell_x_i  (item_q.cell_x),
    .row_ok_i  (row_ok_q),
    .started_i (started),
    .rdata_i   (ram_rdata),
    .wdata_o   (row_wdata),
    .res_o     (row_res)
  );

  ogrid_stats u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (exec_clear),
    .update_i     (exec_add && row_res.update),
    .bump_i       (exec_add && row_res.bump),
    .cell_x_i     (item_q.cell_x),
    .cell_y_i     (item_q.cell_y),
    .started_o    (started),
    .stats_next_o (stats_next)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = row_wdata;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (exec_add) begin
      ram_we = row_res.write;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    row_origin_d = row_origin_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_item_d   = out_item_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SLOT_W'(1);
        if (clr_cnt_q == SLOT_W'(SLOTS - 1)) begin
          state_d   = S_IDLE;
          clr_cnt_d = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_d             = 1'b1;
        out_item_d.status       = ogrid_pkg::ST_DONE;
        out_item_d.occupied     = 1'b0;
        out_item_d.marked_count = stats_next.count;
        out_item_d.low_x        = stats_next.low_x;
        out_item_d.high_x       = stats_next.high_x;
        out_item_d.low_y        = stats_next.low_y;
        out_item_d.high_y       = stats_next.high_y;
        state_d                 = S_IDLE;
        if (exec_clear) begin
          state_d      = S_CLEAR;
          clr_cnt_d    = '0;
          row_origin_d = '0;
        end else if (item_q.opcode == ogrid_pkg::OP_ADD ||
                     item_q.opcode == ogrid_pkg::OP_QUERY) begin
          out_item_d.status   = row_res.status;
          out_item_d.occupied = row_res.occupied;
          if (exec_add && row_res.update && !started) begin
            row_origin_d = item_q.cell_y;
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      row_origin_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      row_origin_q <= row_origin_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (accept) begin
      item_q   <= in_item_i;
      slot_q   <= slot;
      row_ok_q <= row_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An accepted transaction is evaluated in the very next cycle.
  `OG_ASSERT_NEXT(a_accept_exec, accept, state_q == S_EXEC)
  // Every evaluation leaves a result in the output register.
  `OG_ASSERT_NEXT(a_exec_result, state_q == S_EXEC, out_valid_o)
  // The row memory is written only by the clearing pass or an add.
  `OG_ASSERT_IMPL(a_idle_no_write, state_q == S_IDLE, !ram_we)

endmodule
